@@ rtl/md5_pkg.sv @@
// Package for the MD5 message digest block: word types, round constants
// and helper functions. No dependencies.
`default_nettype none
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_number;
        logic        final_word;
    } md5_out_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] KADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] KROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        begin
            w = {x, x} << n;
            rotl = w[63:32];
        end
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        begin
            rl = r[3:0];
            case (r[5:4])
                2'd0: msg_index = rl;
                2'd1: msg_index = 4'((rl << 2) + rl + 4'd1);
                2'd2: msg_index = 4'((rl << 1) + rl + 4'd5);
                default: msg_index = 4'((rl << 3) - rl);
            endcase
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/md5_message_digest.sv @@
// MD5 message digest, one message byte per input word, one round per cycle.
// A byte that does not fill a block is only stored; a filling byte starts the
// rounds and the fold. A last word pads one byte per cycle, runs one or two
// compressions, then shows four digest words. Input stalls outside idle, so
// no byte is taken during rounds on the single round unit, fold, pad or output.
// Reset loads the initial chaining value, a zero bit count and idle state.
`default_nettype none
module md5_message_digest
    import md5_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire md5_in_t  in_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    output md5_out_t      out_data,
    output logic          out_valid,
    input  wire logic     out_stall
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] buf_reg [16];
    logic [63:0] count_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic        fin_reg;
    logic        after_pad_reg;
    logic        len_blk_reg;
    logic        len_wrote_reg;
    logic [1:0]  word_reg;

    logic        take;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [5:0]  pos;
    logic [31:0] f_val, t_sum, t_new;
    logic [3:0]  g_idx;

    assign in_stall = (state_reg != ST_IDLE);
    assign take     = in_valid && !in_stall;
    assign pos      = count_reg[8:3];

    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        g_idx = msg_index(round_reg);
        t_sum = a_reg + f_val + buf_reg[g_idx] + KADD[round_reg];
        t_new = b_reg + rotl(t_sum, KROT[{round_reg[5:4], round_reg[1:0]}]);
    end

    always_comb
    begin
        put_en   = 1'b0;
        put_byte = 8'd0;
        if (state_reg == ST_IDLE && take && in_data.byte_valid)
        begin
            put_en   = 1'b1;
            put_byte = in_data.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            if (!after_pad_reg)
                put_byte = PAD_BYTE;
            else if (len_blk_reg && pos >= LEN_POS)
                put_byte = len_reg[8 * pos[2:0] +: 8];
            else
                put_byte = 8'd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    if (put_en && pos == 6'd63)
                        state_next = ST_ROUND;
                    else if (in_data.last_byte)
                        state_next = ST_PAD;
                end
            ST_ROUND:
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (fin_reg && after_pad_reg && pos == 6'd0 && len_wrote_reg)
                    state_next = ST_OUT;
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            ST_PAD:
                if (pos == 6'd63)
                    state_next = ST_ROUND;
            ST_OUT:
                if (!out_stall && word_reg == 2'd3)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
            a_reg         <= 32'd0;
            b_reg         <= 32'd0;
            c_reg         <= 32'd0;
            d_reg         <= 32'd0;
            count_reg     <= 64'd0;
            len_reg       <= 64'd0;
            round_reg     <= 6'd0;
            fin_reg       <= 1'b0;
            after_pad_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            len_wrote_reg <= 1'b0;
            word_reg      <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
            begin
                count_reg <= count_reg + 64'd8;
                if (state_reg == ST_PAD)
                begin
                    after_pad_reg <= 1'b1;
                    if (!after_pad_reg)
                        len_blk_reg <= (pos < LEN_POS);
                    if (len_blk_reg && pos == 6'd63)
                        len_wrote_reg <= 1'b1;
                end
            end
            if (state_reg == ST_IDLE && take)
            begin
                fin_reg <= in_data.last_byte;
                if (in_data.last_byte)
                    len_reg <= in_data.byte_valid ? count_reg + 64'd8 : count_reg;
            end
            if ((state_reg == ST_IDLE && state_next == ST_ROUND)
                || (state_reg == ST_PAD && state_next == ST_ROUND))
            begin
                a_reg     <= chain_reg[0];
                b_reg     <= chain_reg[1];
                c_reg     <= chain_reg[2];
                d_reg     <= chain_reg[3];
                round_reg <= 6'd0;
            end
            if (state_reg == ST_ROUND)
            begin
                a_reg     <= d_reg;
                b_reg     <= t_new;
                c_reg     <= b_reg;
                d_reg     <= c_reg;
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == ST_FOLD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                word_reg     <= 2'd0;
                if (fin_reg && after_pad_reg)
                    len_blk_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && !out_stall)
            begin
                word_reg <= word_reg + 2'd1;
                if (word_reg == 2'd3)
                begin
                    chain_reg[0]  <= INIT_A;
                    chain_reg[1]  <= INIT_B;
                    chain_reg[2]  <= INIT_C;
                    chain_reg[3]  <= INIT_D;
                    count_reg     <= 64'd0;
                    fin_reg       <= 1'b0;
                    after_pad_reg <= 1'b0;
                    len_blk_reg   <= 1'b0;
                    len_wrote_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            if (pos[1:0] == 2'd0)
                buf_reg[pos[5:2]] <= {24'd0, put_byte};
            else
                buf_reg[pos[5:2]][8 * pos[1:0] +: 8] <= put_byte;
        end
    end

    assign out_valid           = (state_reg == ST_OUT);
    assign out_data.digest_word = chain_reg[word_reg];
    assign out_data.word_number = word_reg;
    assign out_data.final_word  = (word_reg == 2'd3);

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> $past(round_reg) == 6'd63)
        else $error("fold without 64 rounds");
    a_out_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (pos == 6'd0 && fin_reg))
        else $error("digest shown mid-block");
    a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && word_reg != 2'd3) |=> out_valid)
        else $error("digest words cut short");

endmodule
`default_nettype wire
